// File: rtl/skmwp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding k-mer word packer package
// Shared constants, types and the base-alphabet prefix packing function.
// ----------------------------------------------------------------------------
package skmwp_pkg;

   localparam int ALPHABET_SIZE  = 20;
   localparam int PREFIX_SYMBOLS = 6;
   localparam int SUFFIX_SYMBOLS = 12;
   localparam int SYMBOL_BITS    = 5;
   localparam int POSITION_BITS  = 32;

   localparam int WORD_SYMBOLS   = PREFIX_SYMBOLS + SUFFIX_SYMBOLS;
   localparam int PREFIX_W       = 26;
   localparam int SUFFIX_W       = SUFFIX_SYMBOLS * SYMBOL_BITS;
   localparam int WINDOW_START_W = 32;
   localparam int RUN_W          = $clog2(WORD_SYMBOLS + 1);

   typedef logic [SYMBOL_BITS-1:0] symbol_type;

   // Element 0 holds the newest symbol, the top element the oldest.
   typedef symbol_type [WORD_SYMBOLS-1:0] word_type;

   // Element 0 is the least significant digit.
   typedef symbol_type [PREFIX_SYMBOLS-1:0] prefix_digits_type;

   typedef struct packed {
      logic [WINDOW_START_W-1:0] window_start;
      word_type                  word;
   } item_type;

   function automatic logic [PREFIX_W-1:0] prefix_value(input prefix_digits_type digits);
      logic [PREFIX_W-1:0] acc;
      logic [PREFIX_W-1:0] weight;
      acc    = '0;
      weight = PREFIX_W'(1);
      for (int i = 0; i < PREFIX_SYMBOLS; i++) begin
         acc    = acc + PREFIX_W'(digits[i]) * weight;
         weight = PREFIX_W'(weight * PREFIX_W'(ALPHABET_SIZE));
      end
      return acc;
   endfunction

endpackage
`default_nettype wire

// File: rtl/skmwp_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding k-mer word packer: window state
// Holds the symbol window, run length and position counter, and registers
// a snapshot of each full window for the packing stage.
// ----------------------------------------------------------------------------
module skmwp_window
   import skmwp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   take,
   input  wire logic                   start_of_sequence,
   input  wire logic [SYMBOL_BITS-1:0] symbol,
   input  wire logic                   symbol_valid,
   input  wire logic                   pop,
   output      logic                   item_valid,
   output      item_type               item
);

   word_type                   word_ff, word_in;
   logic [RUN_W-1:0]           run_ff, run_in, run_base;
   logic [POSITION_BITS-1:0]   seen_ff, seen_in, seen_base, start_full;
   logic                       item_valid_ff, item_valid_in;
   item_type                   item_ff;
   logic                       symbol_ok;
   logic                       fire;

   always_comb begin
      symbol_ok  = symbol_valid &&
                   ({1'b0, symbol} < (SYMBOL_BITS + 1)'(ALPHABET_SIZE));
      seen_base  = start_of_sequence ? '0 : seen_ff;
      run_base   = start_of_sequence ? '0 : run_ff;
      seen_in    = seen_base + POSITION_BITS'(1);
      start_full = seen_in - POSITION_BITS'(WORD_SYMBOLS);
      word_in    = word_ff;
      run_in     = '0;
      if (symbol_ok) begin
         word_in = {word_ff[WORD_SYMBOLS-2:0], symbol};
         run_in  = (run_base < RUN_W'(WORD_SYMBOLS)) ? run_base + RUN_W'(1) : run_base;
      end
      fire = symbol_ok && (run_in == RUN_W'(WORD_SYMBOLS));
      item_valid_in = item_valid_ff;
      if (take && fire) begin
         item_valid_in = 1'b1;
      end else if (pop) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff       <= '0;
         run_ff        <= '0;
         seen_ff       <= '0;
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         if (take) begin
            word_ff <= word_in;
            run_ff  <= run_in;
            seen_ff <= seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && fire) begin
         item_ff.window_start <= start_full[WINDOW_START_W-1:0];
         item_ff.word         <= word_in;
      end
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

// File: rtl/skmwp_pack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding k-mer word packer: word packing
// Packs a window snapshot into forward and reverse prefix and suffix words
// and holds them in the result register.
// ----------------------------------------------------------------------------
module skmwp_pack
   import skmwp_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      item_valid,
   input  wire item_type                  item,
   output      logic                      pop,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   output      logic [WINDOW_START_W-1:0] rsp_window_start,
   output      logic [PREFIX_W-1:0]       rsp_fwd_prefix,
   output      logic [SUFFIX_W-1:0]       rsp_fwd_suffix,
   output      logic [PREFIX_W-1:0]       rsp_rev_prefix,
   output      logic [SUFFIX_W-1:0]       rsp_rev_suffix
);

   prefix_digits_type          fwd_digits, rev_digits;
   symbol_type [SUFFIX_SYMBOLS-1:0] rev_tail;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [WINDOW_START_W-1:0]  window_start_ff;
   logic [PREFIX_W-1:0]        fwd_prefix_ff, rev_prefix_ff;
   logic [SUFFIX_W-1:0]        fwd_suffix_ff, rev_suffix_ff;

   always_comb begin
      for (int j = 0; j < PREFIX_SYMBOLS; j++) begin
         fwd_digits[j] = item.word[SUFFIX_SYMBOLS + j];
         rev_digits[j] = item.word[PREFIX_SYMBOLS - 1 - j];
      end
      for (int k = 0; k < SUFFIX_SYMBOLS; k++) begin
         rev_tail[k] = item.word[WORD_SYMBOLS - 1 - k];
      end
      pop          = item_valid && (!rsp_valid_ff || rsp_ready);
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         window_start_ff <= item.window_start;
         fwd_prefix_ff   <= prefix_value(fwd_digits);
         fwd_suffix_ff   <= item.word[SUFFIX_SYMBOLS-1:0];
         rev_prefix_ff   <= prefix_value(rev_digits);
         rev_suffix_ff   <= rev_tail;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_start = window_start_ff;
   assign rsp_fwd_prefix   = fwd_prefix_ff;
   assign rsp_fwd_suffix   = fwd_suffix_ff;
   assign rsp_rev_prefix   = rev_prefix_ff;
   assign rsp_rev_suffix   = rev_suffix_ff;

endmodule
`default_nettype wire

// File: rtl/sliding_kmer_word_packer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding k-mer word packer
// Keeps a sliding window of eighteen amino-acid symbols and, for every valid
// symbol that completes a full run, returns the forward and reverse packed
// words with the start position of the window.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  start_of_sequence, symbol,
//                                               symbol_valid
//   rsp_      out        rsp_valid / rsp_ready  window_start, fwd/rev prefix
//                                               and suffix
//
// One request is taken in every cycle while req_ready is high; a result passes
// from the request that causes it through the snapshot and result registers.
// The window state updates when the request is taken, so the next request
// may follow at once. Up to two results can be held while rsp_ready is low;
// req_ready falls only when both are occupied. Reset clears the window, the
// run length and the position counter.
// ----------------------------------------------------------------------------
module sliding_kmer_word_packer
   import skmwp_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_ready,
   input  wire logic                      req_start_of_sequence,
   input  wire logic [SYMBOL_BITS-1:0]    req_symbol,
   input  wire logic                      req_symbol_valid,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   output      logic [WINDOW_START_W-1:0] rsp_window_start,
   output      logic [PREFIX_W-1:0]       rsp_fwd_prefix,
   output      logic [SUFFIX_W-1:0]       rsp_fwd_suffix,
   output      logic [PREFIX_W-1:0]       rsp_rev_prefix,
   output      logic [SUFFIX_W-1:0]       rsp_rev_suffix
);

   logic     item_valid;
   item_type item;
   logic     pop;
   logic     take;

   assign req_ready = !item_valid || pop;
   assign take      = req_valid && req_ready;

   skmwp_window u_window (
      .clock             (clock),
      .reset             (reset),
      .take              (take),
      .start_of_sequence (req_start_of_sequence),
      .symbol            (req_symbol),
      .symbol_valid      (req_symbol_valid),
      .pop               (pop),
      .item_valid        (item_valid),
      .item              (item)
   );

   skmwp_pack u_pack (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item             (item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_window_start (rsp_window_start),
      .rsp_fwd_prefix   (rsp_fwd_prefix),
      .rsp_fwd_suffix   (rsp_fwd_suffix),
      .rsp_rev_prefix   (rsp_rev_prefix),
      .rsp_rev_suffix   (rsp_rev_suffix)
   );

endmodule
`default_nettype wire
